// ===== rtl/tbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types, codes and sizes of the translation block cache.
// ----------------------------------------------------------------------------
package tbc_pkg;

  localparam int unsigned NumEntries = 64;
  localparam int unsigned IdxW       = $clog2(NumEntries);
  localparam int unsigned CntW       = $clog2(NumEntries + 1);

  localparam logic [2:0] MODE_LOOKUP    = 3'd0;
  localparam logic [2:0] MODE_INSERT    = 3'd1;
  localparam logic [2:0] MODE_INV_OWNER = 3'd2;
  localparam logic [2:0] MODE_INV_RANGE = 3'd3;
  localparam logic [2:0] MODE_INV_ALL   = 3'd4;
  localparam logic [2:0] MODE_BUMP      = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BADARG = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;

  localparam logic [2:0] OP_HOLD    = 3'd0;
  localparam logic [2:0] OP_EVAL    = 3'd1;
  localparam logic [2:0] OP_DROP    = 3'd2;
  localparam logic [2:0] OP_COMPACT = 3'd3;
  localparam logic [2:0] OP_SHIFT   = 3'd4;
  localparam logic [2:0] OP_LOAD    = 3'd5;

  typedef struct packed {
    logic [15:0] owner;
    logic [63:0] start_pc;
    logic [63:0] end_pc;
    logic [63:0] gen;
    logic [31:0] handle;
    logic [15:0] words;
    logic [15:0] icount;
  } entry_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic [2:0]      op;
    logic [2:0]      mode;
    logic [CntW-1:0] total;
    entry_t          cmd;
  } cell_ctl_t;

endpackage

// ===== rtl/tbc_cell.sv =====
// ----------------------------------------------------------------------------
// tbc_cell
// One cache slot: holds an entry, matches it against the command, and
// takes its right neighbor's entry when the row shifts or compacts.
// ----------------------------------------------------------------------------
module tbc_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [tbc_pkg::IdxW-1:0] idx,
  input  tbc_pkg::cell_ctl_t     ctl,
  input  logic                   hole_in,
  input  logic                   right_v,
  input  tbc_pkg::entry_t        right_e,
  output logic                   v,
  output tbc_pkg::entry_t        e,
  output logic                   hit,
  output logic                   drop,
  output logic                   hole_out,
  output logic                   need
);
  import tbc_pkg::*;

  logic match;
  logic drop_c;
  logic own_eq;

  always_comb begin
    own_eq = e.owner == ctl.cmd.owner;
    match  = v && own_eq && e.start_pc == ctl.cmd.start_pc && e.gen == ctl.cmd.gen;
    case (ctl.mode)
      MODE_INV_OWNER: drop_c = v && own_eq;
      MODE_INV_RANGE: drop_c = v && own_eq && (e.end_pc > ctl.cmd.start_pc)
                               && (e.start_pc < ctl.cmd.end_pc);
      MODE_INV_ALL:   drop_c = v;
      default:        drop_c = 1'b0;
    endcase
  end

  assign hole_out = hole_in | ~v;
  assign need     = hole_in & v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= 1'b0;
      hit  <= 1'b0;
      drop <= 1'b0;
    end else begin
      case (ctl.op)
        OP_EVAL: begin
          hit  <= match;
          drop <= drop_c;
        end
        OP_DROP:    if (drop) v <= 1'b0;
        OP_COMPACT: if (hole_out) v <= right_v;
        OP_SHIFT:   v <= right_v;
        OP_LOAD:    if (idx == ctl.total[IdxW-1:0]) v <= 1'b1;
        default:    v <= v;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_COMPACT: if (hole_out) e <= right_e;
      OP_SHIFT:   e <= right_e;
      OP_LOAD:    if (idx == ctl.total[IdxW-1:0]) e <= ctl.cmd;
      default:    e <= e;
    endcase
  end

endmodule

// ===== rtl/translation_block_cache_top.sv =====
// ----------------------------------------------------------------------------
// translation_block_cache_top
// Translation block cache over a row of entry cells, oldest entry at cell 0.
// ----------------------------------------------------------------------------
// Sequence: the command beat is taken in IDLE, the cells evaluate in EVAL,
// the result is decided in RESOLVE and registered with strobe. A new beat
// is taken only while busy is low; an owner, all or valid range invalidation
// keeps busy high in COMPACT while the row closes gaps one cell per cycle.
// Reset: all entries invalid, generation counter 1. The receiver cannot
// stall; each result is shown for one cycle under strobe.
module translation_block_cache_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [15:0] owner_id,
  input  logic [63:0] start_pc,
  input  logic [63:0] end_pc,
  input  logic [63:0] generation,
  input  logic [31:0] handle,
  input  logic [15:0] payload_words,
  input  logic [15:0] insn_count,
  output logic        strobe,
  output logic [1:0]  status,
  output logic        hit,
  output logic [31:0] found_handle,
  output logic [15:0] found_words,
  output logic [15:0] found_icount,
  output logic [63:0] found_end_pc,
  output logic [63:0] current_gen,
  output logic [6:0]  removed_count
);
  import tbc_pkg::*;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EVAL    = 2'd1;
  localparam logic [1:0] S_RESOLVE = 2'd2;
  localparam logic [1:0] S_COMPACT = 2'd3;

  logic [1:0]      state, state_next;
  logic [2:0]      cmd_mode;
  entry_t          cmd;
  logic [CntW-1:0] total, total_next;
  logic [63:0]     gen_counter, gen_next;
  cell_ctl_t       ctl;

  logic [NumEntries-1:0] cv, chit, cdrop, cneed;
  logic [NumEntries:0]   hole;
  entry_t                ce [NumEntries];

  logic            any_hit, any_need;
  entry_t          hit_e;
  logic [CntW-1:0] drop_cnt;
  logic            bad_arg;

  logic [1:0]  r_status;
  logic        r_hit;
  entry_t      r_e;
  logic [6:0]  r_removed;

  assign busy = state != S_IDLE;
  assign hole[0] = 1'b0;

  // row of cells; the last cell is fed the command entry during an
  // eviction shift and an empty slot while compacting
  for (genvar i = 0; i < NumEntries; i++) begin : g_cell
    logic   rv;
    entry_t re;
    if (i == NumEntries - 1) begin : g_last
      assign rv = ctl.op == OP_SHIFT;
      assign re = cmd;
    end else begin : g_mid
      assign rv = cv[i+1];
      assign re = ce[i+1];
    end
    tbc_cell u_cell (
      .clk(clk), .rst(rst), .idx(IdxW'(i)), .ctl(ctl),
      .hole_in(hole[i]), .right_v(rv), .right_e(re),
      .v(cv[i]), .e(ce[i]), .hit(chit[i]), .drop(cdrop[i]),
      .hole_out(hole[i+1]), .need(cneed[i])
    );
  end

  // keys are unique, so at most one cell hits: merge with an OR
  always_comb begin
    any_hit  = 1'b0;
    any_need = 1'b0;
    hit_e    = '0;
    drop_cnt = '0;
    for (int i = 0; i < NumEntries; i++) begin
      any_hit  = any_hit | chit[i];
      any_need = any_need | cneed[i];
      hit_e    = hit_e | (chit[i] ? ce[i] : '0);
      drop_cnt = drop_cnt + CntW'(cdrop[i]);
    end
  end

  assign bad_arg = cmd.owner == '0 || cmd.handle == '0 || cmd.words == '0 ||
                   cmd.icount == '0 || cmd.end_pc < cmd.start_pc;

  // sequencer: decide the command in RESOLVE from the registered cell flags
  always_comb begin
    state_next = state;
    total_next = total;
    gen_next   = gen_counter;
    ctl.op     = OP_HOLD;
    ctl.mode   = cmd_mode;
    ctl.total  = total;
    ctl.cmd    = cmd;
    r_status   = ST_OK;
    r_hit      = 1'b0;
    r_e        = '0;
    r_removed  = '0;
    case (state)
      S_IDLE: if (start) state_next = S_EVAL;
      S_EVAL: begin
        ctl.op     = OP_EVAL;
        state_next = S_RESOLVE;
      end
      S_RESOLVE: begin
        state_next = S_IDLE;
        case (cmd_mode)
          MODE_LOOKUP: begin
            if (cmd.owner != '0 && any_hit) begin
              r_hit = 1'b1;
              r_e   = hit_e;
            end
          end
          MODE_INSERT: begin
            if (bad_arg) begin
              r_status = ST_BADARG;
            end else if (cmd.gen != gen_counter) begin
              r_status = ST_STALE;
            end else if (any_hit) begin
              r_hit = 1'b1;
              r_e   = hit_e;
            end else begin
              r_hit = 1'b1;
              r_e   = cmd;
              if (total == CntW'(NumEntries)) begin
                // evict the oldest: shift the whole row left by one
                ctl.op    = OP_SHIFT;
                r_removed = 7'd1;
              end else begin
                ctl.op     = OP_LOAD;
                total_next = total + 1'b1;
              end
            end
          end
          MODE_INV_OWNER, MODE_INV_ALL: begin
            gen_next   = gen_counter + 64'd1;
            ctl.op     = OP_DROP;
            total_next = total - drop_cnt;
            r_removed  = 7'(drop_cnt);
            state_next = S_COMPACT;
          end
          MODE_INV_RANGE: begin
            if (cmd.owner != '0 && cmd.end_pc > cmd.start_pc) begin
              gen_next   = gen_counter + 64'd1;
              ctl.op     = OP_DROP;
              total_next = total - drop_cnt;
              r_removed  = 7'(drop_cnt);
              state_next = S_COMPACT;
            end
          end
          MODE_BUMP: gen_next = gen_counter + 64'd1;
          default:   r_status = ST_BADARG;
        endcase
      end
      S_COMPACT: begin
        // close gaps one cell per cycle until the valid cells are packed
        ctl.op = OP_COMPACT;
        if (!any_need) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      total       <= '0;
      gen_counter <= 64'd1;
      strobe      <= 1'b0;
    end else begin
      state       <= state_next;
      total       <= total_next;
      gen_counter <= gen_next;
      strobe      <= state == S_RESOLVE;
    end
  end

  // latch the command beat; hold result fields until the next beat
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_mode <= mode;
      cmd      <= '{owner: owner_id, start_pc: start_pc, end_pc: end_pc,
                    gen: generation, handle: handle, words: payload_words,
                    icount: insn_count};
    end
    if (state == S_RESOLVE) begin
      status        <= r_status;
      hit           <= r_hit;
      found_handle  <= r_e.handle;
      found_words   <= r_e.words;
      found_icount  <= r_e.icount;
      found_end_pc  <= r_e.end_pc;
      current_gen   <= gen_next;
      removed_count <= r_removed;
    end
  end

  a_strobe_after_resolve: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == S_RESOLVE) else $error("strobe without resolve");
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    total <= CntW'(NumEntries)) else $error("entry total out of range");
  a_idle_packed: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !any_need) else $error("idle with gaps in row");
  a_busy_while_compact: assert property (@(posedge clk) disable iff (rst)
    state == S_COMPACT |-> busy && !strobe || $past(state) == S_RESOLVE)
    else $error("compaction overlaps a new beat");

endmodule
